// ===== src/tcce_pkg.sv =====
// Shared types and constants for the text console character engine.
`default_nettype none

package tcce_pkg;

    // Fixed field widths of the item payloads and the config port.
    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int POS_W = 11;
    localparam int CLR_W = 4;
    localparam int IDX_W = 1;

    // Command codes.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FG = 1'b0;
    localparam logic [IDX_W-1:0] REG_BG = 1'b1;

    // Configuration reset values.
    localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

    // Character codes.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] target_row;
        logic [COL_W-1:0] target_col;
        logic             mark_printed;
    } t_in_item;

    typedef struct packed {
        logic             cell_write;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [15:0]      cell_value;
        logic             scroll_up;
        logic             clear_all;
        logic [POS_W-1:0] cursor_pos;
        logic             status;
    } t_out_item;

endpackage

`default_nettype wire

// ===== src/text_console_char_engine_top.sv =====
// Top level of the text console character engine: item registers, handshake and colors.
`default_nettype none

// Character-cell terminal engine. Each item is either a character (printable
// bytes write one display cell and advance the cursor with line wrap; BS, TAB,
// LF, CR and FF edit the cursor and the per-row last-column table, blank a
// cell (BS) or clear the screen (FF)) or a cursor move. Every item yields
// exactly one result item carrying the optional cell write, scroll and clear
// requests, the new linear cursor position and a status bit for a rejected
// move. The engine takes one item per clock while no result is held: an
// item waits in the input register, the cursor and row table update from
// there, and the result lands in the output register, which drives
// o_out_valid. The cursor/table update loop sets that rate. A stalled
// result holds the pipeline, but one more item is still taken into the
// input register behind it. The user must write colors through the config
// port only while the engine is idle; the block itself does not enforce
// it. The row table lives in flip-flops and is cleared by reset.
module text_console_char_engine_top #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire tcce_pkg::t_in_item         i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output tcce_pkg::t_out_item             o_out_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [tcce_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [tcce_pkg::CLR_W-1:0] i_cfg_data
);
    import tcce_pkg::*;

    logic             r_s1_valid;
    t_in_item         r_s1_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [CLR_W-1:0] r_fg;
    logic [CLR_W-1:0] r_bg;
    logic             advance;
    logic             core_fire;
    t_out_item        core_result;

    // Move the pipeline whenever the output register is free or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign core_fire  = advance && r_s1_valid;
    // Stall the input only when the input register is full and cannot move on.
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out_item <= core_result;
        end
    end

    // Color registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FG: r_fg <= i_cfg_data;
                REG_BG: r_bg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcce_core #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (core_fire),
        .i_item    (r_s1_item),
        .i_fg      (r_fg),
        .i_bg      (r_bg),
        .o_result  (core_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // A written cell always falls inside the display.
    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.cell_write |->
            32'(o_out_item.cell_row) < ROWS && 32'(o_out_item.cell_col) < COLS)
        else $error("cell write outside the display");

    // A scroll leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scroll_up |->
            o_out_item.cursor_pos == POS_W'((ROWS - 1) * COLS))
        else $error("cursor not at bottom row start after scroll");

    // A rejected move causes no display side effect.
    a_status_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |->
            !o_out_item.cell_write && !o_out_item.scroll_up && !o_out_item.clear_all)
        else $error("rejected move produced a display action");

    // The input stalls only behind a full pipeline held by the output side.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

// ===== src/tcce_core.sv =====
// Cursor, printed-position and row table state with the per-item update logic.
`default_nettype none

module tcce_core #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire tcce_pkg::t_in_item        i_item,
    input  wire logic [tcce_pkg::CLR_W-1:0] i_fg,
    input  wire logic [tcce_pkg::CLR_W-1:0] i_bg,
    output tcce_pkg::t_out_item            o_result
);
    import tcce_pkg::*;

    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW      = $clog2(COLS);
    localparam int TAB_MAX = COLS / TAB_STOP + 1;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_prow, n_prow;
    logic [CW-1:0] r_pcol, n_pcol;
    logic [CW-1:0] r_lastcol [ROWS];

    logic          tbl_we;
    logic [RW-1:0] tbl_addr;
    logic [CW-1:0] tbl_val;
    logic          tbl_shift;
    logic          tbl_clear;
    logic          do_scroll;
    logic [CW-1:0] tab_stop;
    logic [CW-1:0] prev_last;
    logic [RW-1:0] row_up;
    logic [7:0]    wr_char;
    t_out_item     res;

    // Next tab stop: smallest multiple of the stop spacing above the column.
    always_comb begin
        tab_stop = CW'(COLS - 1);
        for (int k = TAB_MAX; k >= 1; k--) begin
            if (32'(r_col) < k * TAB_STOP) begin
                tab_stop = CW'(k * TAB_STOP);
            end
        end
    end

    assign row_up    = r_row - RW'(1);
    assign prev_last = (32'(r_lastcol[row_up]) >= COLS) ? CW'(COLS - 1) : r_lastcol[row_up];

    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_prow    = r_prow;
        n_pcol    = r_pcol;
        tbl_we    = 1'b0;
        tbl_addr  = r_row;
        tbl_val   = '0;
        tbl_shift = 1'b0;
        tbl_clear = 1'b0;
        do_scroll = 1'b0;
        wr_char   = CH_SPACE;
        res       = '0;

        if (i_item.cmd == CMD_MOVE) begin
            if (32'(i_item.target_row) >= ROWS || 32'(i_item.target_col) >= COLS) begin
                res.status = 1'b1;
            end else begin
                n_row = RW'(i_item.target_row);
                n_col = CW'(i_item.target_col);
            end
        end else begin
            case (i_item.char_code) inside
                [CH_SPACE:CH_TILDE]: begin
                    res.cell_write = 1'b1;
                    res.cell_row   = ROW_W'(r_row);
                    res.cell_col   = COL_W'(r_col);
                    wr_char        = i_item.char_code;
                    if (32'(r_col) == COLS - 1) begin
                        if (32'(r_row) == ROWS - 1) begin
                            do_scroll = 1'b1;
                        end else begin
                            n_row    = r_row + RW'(1);
                            n_col    = '0;
                            tbl_we   = 1'b1;
                            tbl_addr = r_row + RW'(1);
                        end
                    end else begin
                        n_col   = r_col + CW'(1);
                        tbl_we  = 1'b1;
                        tbl_val = r_col + CW'(1);
                    end
                end
                CH_BS: begin
                    if ((r_prow == r_row && r_col > r_pcol) ||
                        (r_prow < r_row && r_col != '0)) begin
                        n_col          = r_col - CW'(1);
                        tbl_we         = 1'b1;
                        tbl_val        = r_col - CW'(1);
                        res.cell_write = 1'b1;
                        res.cell_row   = ROW_W'(r_row);
                        res.cell_col   = COL_W'(r_col - CW'(1));
                    end else if (r_prow < r_row) begin
                        // Step back onto the end of the previous row.
                        n_row          = row_up;
                        n_col          = prev_last;
                        tbl_we         = 1'b1;
                        tbl_addr       = row_up;
                        tbl_val        = prev_last;
                        res.cell_write = 1'b1;
                        res.cell_row   = ROW_W'(row_up);
                        res.cell_col   = COL_W'(prev_last);
                    end
                end
                CH_TAB: begin
                    if (32'(r_col) + TAB_STOP < COLS - 1) begin
                        n_col   = tab_stop;
                        tbl_val = tab_stop;
                    end else begin
                        n_col   = CW'(COLS - 1);
                        tbl_val = CW'(COLS - 1);
                    end
                    tbl_we = 1'b1;
                end
                CH_LF: begin
                    if (32'(r_row) < ROWS - 1) begin
                        n_row    = r_row + RW'(1);
                        n_col    = '0;
                        tbl_we   = 1'b1;
                        tbl_addr = r_row + RW'(1);
                    end else begin
                        do_scroll = 1'b1;
                    end
                end
                CH_FF: begin
                    res.clear_all = 1'b1;
                    tbl_clear     = 1'b1;
                end
                CH_CR: begin
                    n_col  = '0;
                    tbl_we = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (do_scroll) begin
            res.scroll_up = 1'b1;
            tbl_shift     = 1'b1;
            n_row         = RW'(ROWS - 1);
            n_col         = '0;
            if (r_prow != '0) begin
                n_prow = r_prow - RW'(1);
            end else begin
                n_prow = '0;
                n_pcol = '0;
            end
        end

        if (i_item.mark_printed) begin
            n_prow = n_row;
            n_pcol = n_col;
        end

        if (res.cell_write) begin
            res.cell_value = {i_bg, i_fg, wr_char};
        end
        res.cursor_pos = POS_W'(32'(n_col) + 32'(n_row) * COLS);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_prow <= '0;
            r_pcol <= '0;
            for (int i = 0; i < ROWS; i++) begin
                r_lastcol[i] <= '0;
            end
        end else if (i_advance) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_prow <= n_prow;
            r_pcol <= n_pcol;
            if (tbl_clear) begin
                for (int i = 0; i < ROWS; i++) begin
                    r_lastcol[i] <= '0;
                end
            end else if (tbl_shift) begin
                for (int i = 0; i < ROWS - 1; i++) begin
                    r_lastcol[i] <= r_lastcol[i+1];
                end
                r_lastcol[ROWS-1] <= '0;
            end else if (tbl_we) begin
                r_lastcol[tbl_addr] <= tbl_val;
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/console_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the text console engine: predicts each result item and compares it.
module console_checker #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire tcce_pkg::t_in_item         i_in_item,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire tcce_pkg::t_out_item        i_out_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [tcce_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [tcce_pkg::CLR_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import tcce_pkg::*;

    // Predicted console state.
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [COL_W-1:0] last_col [ROWS];
    logic [ROW_W-1:0] prt_row;
    logic [COL_W-1:0] prt_col;
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;

    t_out_item results_due[$];
    int        fails = 0;

    function automatic t_out_item write_cell(int row, int col, logic [7:0] ch);
        t_out_item res;
        res            = '0;
        res.cell_write = 1'b1;
        res.cell_row   = row[ROW_W-1:0];
        res.cell_col   = col[COL_W-1:0];
        res.cell_value = {bg, fg, ch};
        return res;
    endfunction

    // Shift the row table up one line and park the cursor on the bottom row.
    function automatic void scroll_rows();
        for (int i = 0; i + 1 < ROWS; i++) begin
            last_col[i] = last_col[i + 1];
        end
        last_col[ROWS - 1] = '0;
        cur_row = ROW_W'(ROWS - 1);
        cur_col = '0;
        if (prt_row >= 1) begin
            prt_row = prt_row - 1'b1;
        end else begin
            prt_row = '0;
            prt_col = '0;
        end
    endfunction

    function automatic t_out_item advance_console(t_in_item it);
        t_out_item res;
        int        r;
        int        c;
        int        lc;
        int        pos;
        res = '0;
        r   = int'(cur_row);
        c   = int'(cur_col);
        if (it.cmd == CMD_MOVE) begin
            if (it.target_row >= ROWS || it.target_col >= COLS) begin
                res.status = 1'b1;
            end else begin
                cur_row = it.target_row;
                cur_col = it.target_col;
            end
        end else if (it.char_code >= CH_SPACE && it.char_code <= CH_TILDE) begin
            res = write_cell(r, c, it.char_code);
            c++;
            if (c > COLS - 1) begin
                r++;
                c = 0;
                if (r < ROWS) last_col[r] = '0;
            end
            if (r >= ROWS) begin
                res.scroll_up = 1'b1;
                scroll_rows();
            end else begin
                cur_row     = r[ROW_W-1:0];
                cur_col     = c[COL_W-1:0];
                last_col[r] = c[COL_W-1:0];
            end
        end else if (it.char_code == CH_BS) begin
            if (prt_row == r) begin
                if (c > prt_col) begin
                    c--;
                    cur_col     = c[COL_W-1:0];
                    last_col[r] = c[COL_W-1:0];
                    res         = write_cell(r, c, CH_SPACE);
                end
            end else if (prt_row < r) begin
                if (c > 0) begin
                    c--;
                    cur_col     = c[COL_W-1:0];
                    last_col[r] = c[COL_W-1:0];
                    res         = write_cell(r, c, CH_SPACE);
                end else begin
                    // step back to the end of the previous row
                    lc = int'(last_col[r - 1]);
                    if (lc >= COLS) begin
                        lc              = COLS - 1;
                        last_col[r - 1] = lc[COL_W-1:0];
                    end
                    cur_row = ROW_W'(r - 1);
                    cur_col = lc[COL_W-1:0];
                    res     = write_cell(r - 1, lc, CH_SPACE);
                end
            end
        end else if (it.char_code == CH_TAB) begin
            if (c + TAB_STOP < COLS - 1) c = c + (TAB_STOP - c % TAB_STOP);
            else c = COLS - 1;
            cur_col     = c[COL_W-1:0];
            last_col[r] = c[COL_W-1:0];
        end else if (it.char_code == CH_LF) begin
            if (r < ROWS - 1) begin
                cur_row         = ROW_W'(r + 1);
                cur_col         = '0;
                last_col[r + 1] = '0;
            end else begin
                res.scroll_up = 1'b1;
                scroll_rows();
            end
        end else if (it.char_code == CH_FF) begin
            res.clear_all = 1'b1;
            for (int i = 0; i < ROWS; i++) last_col[i] = '0;
        end else if (it.char_code == CH_CR) begin
            cur_col     = '0;
            last_col[r] = '0;
        end
        if (it.mark_printed) begin
            prt_row = cur_row;
            prt_col = cur_col;
        end
        pos            = int'(cur_col) + int'(cur_row) * COLS;
        res.cursor_pos = pos[POS_W-1:0];
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cur_row = '0;
            cur_col = '0;
            prt_row = '0;
            prt_col = '0;
            fg      = FG_RESET;
            bg      = BG_RESET;
            for (int i = 0; i < ROWS; i++) last_col[i] = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FG) fg = i_cfg_data;
                else if (i_cfg_idx == REG_BG) bg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, i_out_item);
                end else begin
                    want = results_due.pop_front();
                    check_field("cell_write", want.cell_write, i_out_item.cell_write);
                    check_field("cell_row", want.cell_row, i_out_item.cell_row);
                    check_field("cell_col", want.cell_col, i_out_item.cell_col);
                    check_field("cell_value", want.cell_value, i_out_item.cell_value);
                    check_field("scroll_up", want.scroll_up, i_out_item.scroll_up);
                    check_field("clear_all", want.clear_all, i_out_item.clear_all);
                    check_field("cursor_pos", want.cursor_pos, i_out_item.cursor_pos);
                    check_field("status", want.status, i_out_item.status);
                end
            end
            if (i_in_valid && !i_in_stall) results_due.push_back(advance_console(i_in_item));
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the text console engine testbench: clock, reset, stimulus and verdict.
module testbench;
    import tcce_pkg::*;

    localparam int ROWS           = 25;
    localparam int COLS           = 80;
    localparam int TAB_STOP       = 8;
    localparam int CLK_PERIOD     = 10;
    localparam int LONG_HOLD      = 48;   // receiver hold-off that backs up the engine
    localparam int WATCHDOG_LIMIT = 2000; // cycles without any item moving on either channel
    localparam int PHASE_ITEMS    = 105;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_idx   = REG_FG;
    logic [CLR_W-1:0] cfg_data  = '0;
    int               fail_count;
    int               pending;

    // Idle controls for the sender and receiver processes.
    int snd_pct      = 0;
    int rcv_pct      = 0;
    bit quiet        = 1'b0;
    bit hold_off_req = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_console_char_engine_top #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    console_checker #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Build a character item; the move fields carry noise so their bits toggle too.
    function automatic t_in_item char_item(logic [7:0] ch, logic mark);
        t_in_item    it;
        logic [31:0] noise;
        noise           = $urandom;
        it              = noise[$bits(t_in_item)-1:0];
        it.cmd          = CMD_CHAR;
        it.char_code    = ch;
        it.mark_printed = mark;
        return it;
    endfunction

    function automatic t_in_item move_item(int row, int col, logic mark);
        t_in_item    it;
        logic [31:0] noise;
        noise           = $urandom;
        it              = noise[$bits(t_in_item)-1:0];
        it.cmd          = CMD_MOVE;
        it.target_row   = row[ROW_W-1:0];
        it.target_col   = col[COL_W-1:0];
        it.mark_printed = mark;
        return it;
    endfunction

    // Mostly printable text with the usual edit controls mixed in; moves lean
    // toward the bottom rows and the right edge so that wraps and scrolls
    // come often. A few moves go out of bounds and a few bytes are noise.
    function automatic t_in_item random_console_item();
        int       pick;
        logic     mark;
        t_in_item it;
        pick = $urandom_range(99);
        mark = ($urandom_range(9) < 2);
        if (pick < 55) begin
            it = char_item(8'($urandom_range(CH_TILDE, CH_SPACE)), mark);
        end else if (pick < 65) begin
            it = char_item(CH_BS, mark);
        end else if (pick < 70) begin
            it = char_item(CH_TAB, mark);
        end else if (pick < 77) begin
            it = char_item(CH_LF, mark);
        end else if (pick < 81) begin
            it = char_item(CH_CR, mark);
        end else if (pick < 82) begin
            it = char_item(CH_FF, mark);
        end else if (pick < 88) begin
            it = char_item(8'($urandom_range(1) ? $urandom_range(31, 0)
                                                : $urandom_range(255, 127)), mark);
        end else if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) begin
                it = move_item($urandom_range(31, ROWS), $urandom_range(127, 0), mark);
            end else begin
                it = move_item($urandom_range(ROWS - 1, 0), $urandom_range(127, COLS), mark);
            end
        end else begin
            it = move_item($urandom_range(1) ? $urandom_range(ROWS - 1, ROWS - 5)
                                             : $urandom_range(ROWS - 1, 0),
                           $urandom_range(1) ? $urandom_range(COLS - 1, COLS - 10)
                                             : $urandom_range(COLS - 1, 0), mark);
        end
        return it;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    // Offer one item, after an optional idle burst, and hold it until taken.
    task automatic send_item(input t_in_item it);
        int gap;
        if (!quiet && snd_pct != 0 && $urandom_range(99) < snd_pct) begin
            gap = $urandom_range(13, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CLR_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : receiver
        int n;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall    <= 1'b0;
                hold_off_req = 1'b0;
            end else if (!quiet && rcv_pct != 0 && $urandom_range(99) < rcv_pct) begin
                n = $urandom_range(13, 1);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        logic [CLR_W-1:0] fg_plan [5];
        logic [CLR_W-1:0] bg_plan [5];
        fg_plan = '{4'd15, 4'd0, 4'd0, 4'd10, 4'd3};
        bg_plan = '{4'd15, 4'd0, 4'd0, 4'd5, 4'd12};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at reset colors.
        send_item(move_item(0, 0, 1'b1));          // anchor the printed position at home
        send_item(char_item(CH_SPACE, 1'b0));      // lowest printable byte
        send_item(char_item(CH_TILDE, 1'b0));      // highest printable byte
        send_item(char_item(8'd31, 1'b0));         // just below printable: ignored
        send_item(char_item(8'd127, 1'b0));        // just above printable: ignored
        send_item(char_item(8'd255, 1'b0));
        send_item(char_item(8'd0, 1'b0));
        send_item(char_item(CH_BS, 1'b0));         // back one column, blank it
        send_item(char_item(CH_TAB, 1'b0));
        send_item(char_item(CH_CR, 1'b0));
        send_item(char_item(CH_BS, 1'b0));         // at printed position: no action
        send_item(move_item(ROWS - 1, COLS - 1, 1'b1));
        send_item(char_item(8'd90, 1'b0));         // wrap on the bottom row, scroll
        send_item(move_item(ROWS, 0, 1'b0));       // row out of bounds
        send_item(move_item(0, COLS, 1'b0));       // column out of bounds
        send_item(move_item(31, 127, 1'b0));       // all ones
        send_item(move_item(3, 5, 1'b1));
        send_item(move_item(4, 0, 1'b0));
        send_item(char_item(CH_BS, 1'b0));         // back onto the previous row
        send_item(move_item(2, 0, 1'b0));
        send_item(char_item(CH_BS, 1'b0));         // printed row below cursor row: no action
        send_item(move_item(2, 70, 1'b0));
        send_item(char_item(CH_TAB, 1'b0));        // to the next stop
        send_item(char_item(CH_TAB, 1'b0));        // stop beyond the row: clamp to last column
        send_item(char_item(CH_FF, 1'b0));
        send_item(move_item(0, 0, 1'b1));
        send_item(move_item(ROWS - 1, 0, 1'b0));
        send_item(char_item(CH_LF, 1'b0));         // scroll with printed row at top

        // Random phases, each at its own color setting.
        for (int p = 0; p < 5; p++) begin
            settle();
            write_reg(REG_FG, (p == 2) ? 4'($urandom_range(15)) : fg_plan[p]);
            write_reg(REG_BG, (p == 2) ? 4'($urandom_range(15)) : bg_plan[p]);
            if (p == 1) begin
                // Hold the receiver off and offer 12 items so that the input stalls.
                snd_pct      = 0;
                hold_off_req = 1'b1;
                repeat (12) send_item(random_console_item());
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 35 == 0) begin
                    snd_pct = pick_idle_pct();
                    rcv_pct = pick_idle_pct();
                end
                if (p == 4 && k == 45) quiet = 1'b1;
                send_item(random_console_item());
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
